/* src/dlpg_pkg.sv */
// Shared types for the DDA line point generator.
// No dependencies; imported by the sequencer and the top level.
package dlpg_pkg;

    // sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } seq_state_t;

    // controls from sequencer to datapath
    typedef struct packed
    {
        logic in_ready;   // input word may be taken
        logic latch;      // capture endpoints
        logic setup;      // load differences, step count, positions
        logic out_valid;  // current point is on the output
        logic advance;    // point taken, step both axes
    } seq_ctrl_t;

endpackage

/* src/dda_line_point_generator_top.sv */
// Top level of the DDA line point generator.
// Depends on dlpg_pkg, dlpg_seq and dlpg_step_unit.
//
//  channel   dir  signals                        word contents
//  s_axis    in   tvalid tready tdata            one segment (two endpoints)
//  m_axis    out  tvalid tready tdata tlast      one pixel point, tlast on last
//
// Sequence: a segment with steps = max(|dr|, |dc|) is accepted in idle, then
// passes a setup state (differences, abs, max) and a run of steps + 1 points
// before the sequencer returns to idle for the next accept.
// The single step unit turns out one point per cycle for both axes while
// m_axis_tready is high.
// Reset: rst_n is asynchronous, active low; it returns the sequencer to
// idle. Datapath registers are loaded before use and carry no reset.
// Stalls: s_axis_tready is high only while idle. A point holds on m_axis
// until taken; a low m_axis_tready freezes the step unit.
//
// Position per axis is kept as a quotient and remainder of
// ((2*a1+1)*steps + 2*k*d) / (2*steps): the remainder starts at steps and
// each point adds 2*d, wrapping by 2*steps with a +/-1 on the position.
module dda_line_point_generator_top
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // start_row, start_col, end_row, end_col (low to high), zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // point_row, point_col (low to high), zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                   m_axis_tlast   // last_point
);

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((2*CB+7)/8)*8;

    seq_ctrl_t ctrl;

    // latched endpoints
    logic [CB-1:0] start_row_reg;
    logic [CB-1:0] start_col_reg;
    logic [CB-1:0] end_row_reg;
    logic [CB-1:0] end_col_reg;

    // per-segment constants and running state
    logic [1:0][CB:0]   delta_reg;
    logic [CB-1:0]      steps_reg;
    logic [1:0][CB-1:0] pos_reg;
    logic [1:0][CB:0]   rem_reg;
    logic [CB-1:0]      idx_reg;

    // setup arithmetic
    logic [CB:0]   diff_row;
    logic [CB:0]   diff_col;
    logic [CB:0]   neg_row;
    logic [CB:0]   neg_col;
    logic [CB-1:0] abs_row;
    logic [CB-1:0] abs_col;
    logic [CB-1:0] steps_next;

    logic [1:0][CB-1:0] pos_next;
    logic [1:0][CB:0]   rem_next;
    logic               last;

    assign diff_row = {1'b0, end_row_reg} - {1'b0, start_row_reg};
    assign diff_col = {1'b0, end_col_reg} - {1'b0, start_col_reg};
    assign neg_row  = -diff_row;
    assign neg_col  = -diff_col;
    assign abs_row  = diff_row[CB] ? neg_row[CB-1:0] : diff_row[CB-1:0];
    assign abs_col  = diff_col[CB] ? neg_col[CB-1:0] : diff_col[CB-1:0];
    assign steps_next = (abs_row > abs_col) ? abs_row : abs_col;

    assign last = (idx_reg == steps_reg);

    dlpg_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .last      (last),
        .ctrl      (ctrl)
    );

    dlpg_step_unit #(
        .COORD_BITS (CB)
    ) u_step (
        .pos      (pos_reg),
        .rem      (rem_reg),
        .delta    (delta_reg),
        .steps    (steps_reg),
        .pos_next (pos_next),
        .rem_next (rem_next)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            start_row_reg <= s_axis_tdata[CB-1:0];
            start_col_reg <= s_axis_tdata[2*CB-1:CB];
            end_row_reg   <= s_axis_tdata[3*CB-1:2*CB];
            end_col_reg   <= s_axis_tdata[4*CB-1:3*CB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.setup)
        begin
            delta_reg[0] <= diff_row;
            delta_reg[1] <= diff_col;
            steps_reg    <= steps_next;
            pos_reg[0]   <= start_row_reg;
            pos_reg[1]   <= start_col_reg;
            rem_reg[0]   <= {1'b0, steps_next};   // the half-pixel offset
            rem_reg[1]   <= {1'b0, steps_next};
            idx_reg      <= '0;
        end
        else if (ctrl.advance)
        begin
            pos_reg <= pos_next;
            rem_reg <= rem_next;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tvalid = ctrl.out_valid;
    assign m_axis_tdata  = OUT_W'({pos_reg[1], pos_reg[0]});
    assign m_axis_tlast  = ctrl.out_valid && last;

    // the last point of a run lands exactly on the end point
    a_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (pos_reg[0] == end_row_reg) && (pos_reg[1] == end_col_reg))
        else $error("last point differs from end point");

    // remainders stay below twice the step count during a run
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (steps_reg != '0)) |->
            (rem_reg[0] < {steps_reg, 1'b0}) && (rem_reg[1] < {steps_reg, 1'b0}))
        else $error("remainder out of range");

    // the point counter never passes the step count
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (idx_reg <= steps_reg))
        else $error("point index past step count");

endmodule

/* src/dlpg_step_unit.sv */
// Shared per-point step unit: one add and compare/correct per axis.
// Depends on nothing; instantiated by the top level.
module dlpg_step_unit #(
    parameter int COORD_BITS = 6
) (
    input  logic [1:0][COORD_BITS-1:0] pos,       // current positions (row, col)
    input  logic [1:0][COORD_BITS:0]   rem,       // remainders in [0, 2*steps)
    input  logic [1:0][COORD_BITS:0]   delta,     // signed differences
    input  logic [COORD_BITS-1:0]      steps,
    output logic [1:0][COORD_BITS-1:0] pos_next,
    output logic [1:0][COORD_BITS:0]   rem_next
);

    localparam int RW = COORD_BITS + 3;

    logic [RW-1:0] twice_steps;

    assign twice_steps = {2'b00, steps, 1'b0};

    for (genvar i = 0; i < 2; i++) begin : g_lane
        logic [RW-1:0] sum;
        logic [RW-1:0] sum_sub;
        logic [RW-1:0] sum_add;

        // remainder plus twice the difference
        assign sum     = {2'b00, rem[i]} + {delta[i][COORD_BITS], delta[i], 1'b0};
        assign sum_sub = sum - twice_steps;
        assign sum_add = sum + twice_steps;

        always_comb
        begin
            priority if (!sum[RW-1] && (sum >= twice_steps))
            begin
                pos_next[i] = pos[i] + 1'b1;
                rem_next[i] = sum_sub[COORD_BITS:0];
            end
            else if (sum[RW-1])
            begin
                pos_next[i] = pos[i] - 1'b1;
                rem_next[i] = sum_add[COORD_BITS:0];
            end
            else
            begin
                pos_next[i] = pos[i];
                rem_next[i] = sum[COORD_BITS:0];
            end
        end
    end

endmodule

/* src/dlpg_seq.sv */
// Sequencer for the DDA line point generator: latch, setup, point run.
// Depends on dlpg_pkg; instantiated by the top level.
module dlpg_seq
    import dlpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    input  logic      last,
    output seq_ctrl_t ctrl
);

    seq_state_t state_reg;
    seq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
                state_next = ST_RUN;
            ST_RUN:
            begin
                if (out_ready && last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.latch    = in_valid;
            end
            ST_SETUP:
                ctrl.setup = 1'b1;
            ST_RUN:
            begin
                ctrl.out_valid = 1'b1;
                ctrl.advance   = out_ready;
            end
            default:
                ctrl = '0;
        endcase
    end

    // input and output sides never open together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.in_ready && ctrl.out_valid))
        else $error("input ready while output valid");

    // an accepted word is always followed by the setup cycle
    a_setup: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.latch |=> ctrl.setup)
        else $error("setup did not follow accept");

    // run ends only on the last point being taken
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.out_valid && !(out_ready && last)) |=> ctrl.out_valid)
        else $error("run ended early");

endmodule

/* test/testbench.sv */
// Self-checking testbench for dda_line_point_generator_top.
// It needs only the RTL. Each segment is rasterized here to predict the
// pixel words that the block must emit, and every word is checked in order.
module testbench;

    localparam int COORD_BITS   = 6;
    localparam int SEG_BITS     = 4*COORD_BITS;
    localparam int IN_BITS      = ((4*COORD_BITS+7)/8)*8;
    localparam int OUT_BITS     = ((2*COORD_BITS+7)/8)*8;
    localparam int STALL_LIMIT  = 1000;  // cycles with no word moving on either side
    localparam int LONG_HOLD    = 300;   // output back-pressure stretch
    localparam int SETTLE_CYCLES = 70;   // a full-length segment plus setup

    typedef struct packed
    {
        logic [COORD_BITS-1:0] end_col;
        logic [COORD_BITS-1:0] end_row;
        logic [COORD_BITS-1:0] start_col;
        logic [COORD_BITS-1:0] start_row;
    } segment_t;

    typedef struct
    {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic                  last;
    } pixel_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata;   // start_row, start_col, end_row, end_col
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;   // point_row, point_col, zero pad
    logic                m_axis_tlast;   // last_point

    pixel_t pending_pixels[$];   // pixels predicted but not yet seen
    pixel_t expected_pixel;
    int     mismatches = 0;
    int     quiet_cycles = 0;
    bit     gaps_on = 1'b1;      // random idling on both sides
    int     sink_hold_cycles = 0;

    dda_line_point_generator_top #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Append one predicted pixel at the tail of the queue.
    function automatic void queue_pixel(input pixel_t px);
        pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    // Exact DDA: per axis, point k = floor(((2*a1+1)*steps + 2*k*d) / (2*steps)).
    // The numerator never drops below steps, so plain integer division is floor.
    function automatic void rasterize_segment(input segment_t seg);
        int     r1;
        int     c1;
        int     dr;
        int     dc;
        int     steps;
        int     num_row;
        int     num_col;
        pixel_t px;
        r1 = int'(seg.start_row);
        c1 = int'(seg.start_col);
        dr = int'(seg.end_row) - r1;
        dc = int'(seg.end_col) - c1;
        steps = (dr < 0) ? -dr : dr;
        if (((dc < 0) ? -dc : dc) > steps)
        begin
            steps = (dc < 0) ? -dc : dc;
        end
        if (steps == 0)
        begin
            // degenerate segment: just the start pixel, marked last
            px.row  = seg.start_row;
            px.col  = seg.start_col;
            px.last = 1'b1;
            queue_pixel(px);
        end
        else
        begin
            for (int k = 0; k <= steps; k++)
            begin
                num_row = (2*r1 + 1)*steps + 2*k*dr;
                num_col = (2*c1 + 1)*steps + 2*k*dc;
                px.row  = COORD_BITS'(num_row / (2*steps));
                px.col  = COORD_BITS'(num_col / (2*steps));
                px.last = (k == steps);
                queue_pixel(px);
            end
        end
    endfunction

    // Offer one segment word, after a random gap; tvalid stays high when
    // the next word follows with no gap, so it is never dropped and raised
    // in the same step.
    task automatic send_segment(input segment_t seg);
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seg;
        do
            @(posedge clk);
        while (!s_axis_tready);
        rasterize_segment(seg);
    endtask

    function automatic segment_t make_segment(input int r1, input int c1, input int r2,
                                              input int c2);
        segment_t seg;
        seg.start_row = COORD_BITS'(r1);
        seg.start_col = COORD_BITS'(c1);
        seg.end_row   = COORD_BITS'(r2);
        seg.end_col   = COORD_BITS'(c2);
        return seg;
    endfunction

    // Withdraw the last word, then wait until every predicted pixel is seen.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Equal endpoints: one pixel, marked last.
    task automatic test_single_point();
        send_segment(make_segment(0, 0, 0, 0));
        send_segment(make_segment(63, 63, 63, 63));
        send_segment(make_segment(17, 42, 17, 42));
        send_segment(make_segment(63, 0, 63, 0));
    endtask

    // Neighboring endpoints: start pixel then end pixel.
    task automatic test_neighbors();
        send_segment(make_segment(5, 5, 6, 6));
        send_segment(make_segment(10, 10, 9, 10));
        send_segment(make_segment(0, 63, 1, 62));
        send_segment(make_segment(63, 0, 63, 1));
        send_segment(make_segment(30, 31, 29, 30));
    endtask

    // Full-tile spans, axis-aligned lines and segments in five of the eight octants.
    task automatic test_extremes_and_octants();
        send_segment(make_segment(0, 0, 63, 63));
        send_segment(make_segment(63, 63, 0, 0));
        send_segment(make_segment(0, 63, 63, 0));
        send_segment(make_segment(63, 0, 0, 63));
        send_segment(make_segment(0, 0, 63, 0));
        send_segment(make_segment(0, 0, 0, 63));
        send_segment(make_segment(0, 0, 63, 31));
        send_segment(make_segment(63, 10, 0, 40));
        send_segment(make_segment(20, 20, 27, 23));
        send_segment(make_segment(20, 20, 23, 13));
        send_segment(make_segment(20, 20, 13, 17));
        send_segment(make_segment(20, 20, 17, 27));
        send_segment(make_segment(40, 8, 2, 50));
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering:
    // the block parks a pixel on the output and drops s_axis_tready.
    task automatic test_output_backpressure();
        sink_hold_cycles = LONG_HOLD;
        send_segment(make_segment(3, 60, 50, 10));
        send_segment(make_segment(0, 0, 12, 5));
        send_segment(make_segment(33, 2, 33, 2));
        send_segment(make_segment(61, 61, 40, 58));
    endtask

    // Sender pauses until the block has emitted everything.
    task automatic test_drain_pause();
        send_segment(make_segment(8, 50, 19, 44));
        wait_for_drain();
        send_segment(make_segment(1, 2, 62, 61));
        wait_for_drain();
    endtask

    // Random segments, a third of them short; some stretches with no idling.
    task automatic test_random_segments(input int count);
        segment_t seg;
        int       r2;
        int       c2;
        for (int i = 0; i < count; i++)
        begin
            gaps_on = (i % 40) >= 10;
            seg = segment_t'(SEG_BITS'($urandom()));
            if ($urandom_range(0, 2) == 0)
            begin
                r2 = int'(seg.start_row) + int'($urandom_range(0, 8)) - 4;
                c2 = int'(seg.start_col) + int'($urandom_range(0, 8)) - 4;
                seg.end_row = COORD_BITS'((r2 < 0) ? 0 : ((r2 > 63) ? 63 : r2));
                seg.end_col = COORD_BITS'((c2 < 0) ? 0 : ((c2 > 63) ? 63 : c2));
            end
            send_segment(seg);
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: random stall before each word, or one long hold on request.
    initial
    begin : pixel_sink
        int stall;
        wait (rst_n);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            else
            begin
                stall = gaps_on ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Compare each accepted pixel word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel: row %0d col %0d last %0b",
                       m_axis_tdata[COORD_BITS-1:0],
                       m_axis_tdata[2*COORD_BITS-1:COORD_BITS], m_axis_tlast);
                mismatches++;
            end
            else
            begin
                expected_pixel = pending_pixels.pop_front();
                if (m_axis_tdata[COORD_BITS-1:0] !== expected_pixel.row)
                begin
                    $error("point_row: expected %0d, got %0d", expected_pixel.row,
                           m_axis_tdata[COORD_BITS-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[2*COORD_BITS-1:COORD_BITS] !== expected_pixel.col)
                begin
                    $error("point_col: expected %0d, got %0d", expected_pixel.col,
                           m_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
                    mismatches++;
                end
                if (m_axis_tlast !== expected_pixel.last)
                begin
                    $error("last_point: expected %0b, got %0b", expected_pixel.last,
                           m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: no word moving on either side for too long means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_point();
        test_neighbors();
        test_extremes_and_octants();
        test_output_backpressure();
        test_drain_pause();
        test_random_segments(82);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
